// ===== rtl/core/rpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and constants for the reference-counted page allocator:
// request and status codes, field widths, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned PAGE_W   = 15;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCNT_W   = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 3'd0,
    REQ_FREE  = 3'd1,
    REQ_INC   = 3'd2,
    REQ_DEC   = 3'd3,
    REQ_ADD   = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_OOM   = 3'd1,
    STAT_RANGE = 3'd2,
    STAT_UNDER = 3'd3,
    STAT_OVER  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } ctl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;    // sweep one count entry to zero
    logic capture;  // latch the item and read both memories
    logic commit;   // update memories and load the result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last; // sweep is at the final entry
    logic out_free; // result register can take a new item
  } dp_sts_t;

endpackage

// ===== rtl/core/rpa_req_if.sv =====
// ----------------------------------------------------------------------------
// rpa_req_if
// Request channel: valid/ready handshake with request type and page number.
// ----------------------------------------------------------------------------
interface rpa_req_if;
  import rpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PAGE_W-1:0] page_index;

  modport source (output valid, output req_type, output page_index, input ready);
  modport sink   (input valid, input req_type, input page_index, output ready);

endinterface

// ===== rtl/core/rpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rpa_rsp_if
// Response channel: valid/ready handshake with status, page, count and the
// released flag.
// ----------------------------------------------------------------------------
interface rpa_rsp_if;
  import rpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   result_page;
  logic [OCNT_W-1:0]   new_count;
  logic                page_released;

  modport source (output valid, output status, output result_page, output new_count,
                  output page_released, input ready);
  modport sink   (input valid, input status, input result_page, input new_count,
                  input page_released, output ready);

endinterface

// ===== rtl/core/rpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpa_ctrl
// Controller: runs the count-memory clearing sweep after reset, then takes
// one item at a time through capture and commit.
// ----------------------------------------------------------------------------
module rpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rpa_pkg::dp_sts_t  sts_i,
  output rpa_pkg::dp_cmd_t  cmd_o
);
  import rpa_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        // hold until the result register frees up
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/rpa_datapath.sv =====
// ----------------------------------------------------------------------------
// rpa_datapath
// Count memory, free-page stack, stack depth, first_page and result registers.
// Reads both memories on capture, writes them on commit; clear zeroes counts.
// ----------------------------------------------------------------------------
module rpa_datapath #(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpa_pkg::dp_cmd_t              cmd_i,
  output rpa_pkg::dp_sts_t              sts_o,
  input  logic                          cfg_we_i,
  input  logic [rpa_pkg::PAGE_W-1:0]    cfg_wdata_i,
  input  logic [rpa_pkg::REQ_W-1:0]     req_type_i,
  input  logic [rpa_pkg::PAGE_W-1:0]    page_index_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [rpa_pkg::STATUS_W-1:0]  status_o,
  output logic [rpa_pkg::PAGE_W-1:0]    result_page_o,
  output logic [rpa_pkg::OCNT_W-1:0]    new_count_o,
  output logic                          page_released_o
);
  import rpa_pkg::*;

  localparam int unsigned AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned DW = $clog2(NUM_PAGES + 1);
  localparam logic [DW-1:0]         DEPTH_FULL = DW'(NUM_PAGES);
  localparam logic [AW-1:0]         ADDR_LAST  = AW'(NUM_PAGES - 1);
  localparam logic [31:0]           NUM_PAGES_W = 32'(NUM_PAGES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);

  function automatic logic [AW-1:0] to_addr(input logic [PAGE_W-1:0] p);
    logic [PAGE_W+AW-1:0] w;
    w = {{AW{1'b0}}, p};
    return w[AW-1:0];
  endfunction

  function automatic logic [OCNT_W-1:0] to_ocnt(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+OCNT_W-1:0] w;
    w = {{OCNT_W{1'b0}}, c};
    return w[OCNT_W-1:0];
  endfunction

  // memories
  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [PAGE_W-1:0]     stk_mem [NUM_PAGES];

  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [PAGE_W-1:0]     stk_rd_q;
  logic [REQ_W-1:0]      req_q;
  logic [PAGE_W-1:0]     page_q;
  logic [PAGE_W-1:0]     first_page_q;
  logic [DW-1:0]         depth_q, depth_d;
  logic [AW-1:0]         clr_addr_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [PAGE_W-1:0]     result_page_q;
  logic [OCNT_W-1:0]     new_count_q;
  logic                  released_q;

  // commit-side results
  logic                  cnt_we_c;
  logic [AW-1:0]         cnt_waddr_c;
  logic [COUNT_BITS-1:0] cnt_wdata_c;
  logic                  stk_we_c;
  status_e               res_status;
  logic [PAGE_W-1:0]     res_page;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  res_rel;

  logic                  cnt_we;
  logic [AW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;

  logic [DW-1:0]         depth_m1;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  in_range;
  logic                  stack_full;

  assign depth_m1   = depth_q - DW'(1);
  assign cnt_dec    = cnt_rd_q - COUNT_ONE;
  assign cnt_inc    = cnt_rd_q + COUNT_ONE;
  assign stack_full = (depth_q == DEPTH_FULL);
  assign in_range   = (page_q >= first_page_q) && ({17'd0, page_q} < NUM_PAGES_W);

  assign sts_o.clr_last = (clr_addr_q == ADDR_LAST);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cnt_we_c    = 1'b0;
    cnt_waddr_c = to_addr(page_q);
    cnt_wdata_c = '0;
    stk_we_c    = 1'b0;
    depth_d     = depth_q;
    res_status  = STAT_OK;
    res_page    = page_q;
    res_cnt     = '0;
    res_rel     = 1'b0;
    if (req_q == REQ_ALLOC) begin
      if (depth_q == '0) begin
        res_status = STAT_OOM;
        res_page   = '0;
      end else begin
        depth_d     = depth_m1;
        cnt_we_c    = 1'b1;
        cnt_waddr_c = to_addr(stk_rd_q);
        cnt_wdata_c = COUNT_ONE;
        res_page    = stk_rd_q;
        res_cnt     = COUNT_ONE;
      end
    end else if (req_q > REQ_W'(REQ_ADD)) begin
      // unknown request: report and change nothing
      res_status = STAT_OK;
    end else if (!in_range) begin
      res_status = STAT_RANGE;
    end else begin
      case (req_q)
        REQ_FREE: begin
          if (cnt_rd_q == '0) begin
            res_status = STAT_UNDER;
          end else begin
            cnt_we_c    = 1'b1;
            cnt_wdata_c = cnt_dec;
            res_cnt     = cnt_dec;
            if (cnt_dec == '0 && !stack_full) begin
              stk_we_c = 1'b1;
              depth_d  = depth_q + DW'(1);
              res_rel  = 1'b1;
            end
          end
        end
        REQ_INC: begin
          if (cnt_rd_q == COUNT_MAX) begin
            res_status = STAT_OVER;
            res_cnt    = COUNT_MAX;
          end else begin
            cnt_we_c    = 1'b1;
            cnt_wdata_c = cnt_inc;
            res_cnt     = cnt_inc;
          end
        end
        REQ_DEC: begin
          if (cnt_rd_q == '0) begin
            res_status = STAT_UNDER;
          end else begin
            cnt_we_c    = 1'b1;
            cnt_wdata_c = cnt_dec;
            res_cnt     = cnt_dec;
          end
        end
        REQ_ADD: begin
          // count goes to one and straight back to zero, then push if the stack is not full
          cnt_we_c    = 1'b1;
          cnt_wdata_c = '0;
          if (!stack_full) begin
            stk_we_c = 1'b1;
            depth_d  = depth_q + DW'(1);
            res_rel  = 1'b1;
          end
        end
        default: begin
          res_status = STAT_OK;
        end
      endcase
    end
  end

  // clearing sweep owns the count write port until done
  always_comb begin
    if (cmd_i.clear) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr_q;
      cnt_wdata = '0;
    end else begin
      cnt_we    = cmd_i.commit && cnt_we_c;
      cnt_waddr = cnt_waddr_c;
      cnt_wdata = cnt_wdata_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cmd_i.capture) begin
      cnt_rd_q <= cnt_mem[to_addr(page_index_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && stk_we_c) begin
      stk_mem[depth_q[AW-1:0]] <= page_q;
    end
    if (cmd_i.capture) begin
      stk_rd_q <= stk_mem[depth_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      page_q <= page_index_i;
    end
    if (cmd_i.commit) begin
      status_q      <= res_status;
      result_page_q <= res_page;
      new_count_q   <= to_ocnt(res_cnt);
      released_q    <= res_rel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q <= '0;
      depth_q      <= '0;
      clr_addr_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        first_page_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        depth_q <= depth_d;
      end
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_page_o   = result_page_q;
  assign new_count_o     = new_count_q;
  assign page_released_o = released_q;

endmodule

// ===== rtl/core/refcounted_page_allocator_unit.sv =====
// The item is captured and both memories read in S_IDLE; the result register
// loads on commit in S_EXEC. One item at a time: a new item is taken only
// after the last one commits (read, then read-modify-write commit of the count
// memory and the free stack); a stalled result holds the commit step.
// Reset: after reset the reference-count memory is swept to zero, one entry
// per cycle, for all NUM_PAGES entries; no item is accepted during the sweep.
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit
// Page allocator with a LIFO free stack and saturating per-page reference
// counts. Controller and datapath joined by command and status bundles.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_unit #(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rpa_pkg::PAGE_W-1:0]  cfg_wdata_i,
  rpa_req_if.sink                     req_i,
  rpa_rsp_if.source                   rsp_o
);
  import rpa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpa_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_i.req_type),
    .page_index_i    (req_i.page_index),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .status_o        (rsp_o.status),
    .result_page_o   (rsp_o.result_page),
    .new_count_o     (rsp_o.new_count),
    .page_released_o (rsp_o.page_released)
  );

endmodule
